// ----- hw/rtl/lebuf_pkg.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared types, codes and sizes of the line edit buffer and its cell chain.
// ----------------------------------------------------------------------------
package lebuf_pkg;

	localparam int LINE_CELLS   = 64;
	localparam int CAPACITY     = 64;
	localparam int SCREEN_COLS  = 64;

	localparam logic [6:0] MAX_LEN_RESET = 7'd64;
	localparam logic [5:0] STEP_LAST     = 6'(LINE_CELLS - 1);

	localparam logic [2:0] KIND_BYTE   = 3'd0;
	localparam logic [2:0] KIND_DELETE = 3'd1;
	localparam logic [2:0] KIND_LEFT   = 3'd2;
	localparam logic [2:0] KIND_RIGHT  = 3'd3;
	localparam logic [2:0] KIND_HOME   = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	localparam logic [7:0] KEY_ENTER     = 8'd10;
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] PRINT_LOW     = 8'd32;
	localparam logic [7:0] PRINT_HIGH    = 8'd126;
	localparam logic [7:0] SPACE_CHAR    = 8'd32;

	localparam logic [1:0] CFG_MAX_LEN    = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_COL = 2'd1;

	typedef enum logic [1:0] {
		OUT_MOVE = 2'd0,
		OUT_CELL = 2'd1,
		OUT_CHAR = 2'd2,
		OUT_DONE = 2'd3
	} out_kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT
	} cell_op_t;

	typedef enum logic [1:0] {
		CH_HOLD,
		CH_ROTATE,
		CH_INSERT,
		CH_REMOVE
	} chain_mode_t;

	typedef struct packed {
		chain_mode_t mode;
		logic [5:0]  pos;
		logic [7:0]  key;
	} chain_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef enum logic {
		SCAN_REDRAW,
		SCAN_ENTER
	} scan_mode_t;

endpackage

// ----- hw/rtl/lebuf_cell.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer cell
// Holds one character and loads it from the key or from either neighbor.
// ----------------------------------------------------------------------------
module lebuf_cell (
	input  logic                clk,
	input  lebuf_pkg::cell_op_t op,
	input  logic [7:0]          key,
	input  logic [7:0]          left,
	input  logic [7:0]          right,
	output logic [7:0]          value
);

	logic [7:0] value_q;

	always_ff @(posedge clk) begin
		case (op)
			lebuf_pkg::CELL_LOAD:       value_q <= key;
			lebuf_pkg::CELL_FROM_LEFT:  value_q <= left;
			lebuf_pkg::CELL_FROM_RIGHT: value_q <= right;
			default:                    value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

// ----- hw/rtl/lebuf_chain.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer cell chain
// A ring of character cells that inserts, removes and rotates the line.
// ----------------------------------------------------------------------------
module lebuf_chain (
	input  logic                   clk,
	input  lebuf_pkg::chain_ctrl_t ctrl,
	output logic [7:0]             head
);

	logic [7:0]          vals [lebuf_pkg::LINE_CELLS];
	lebuf_pkg::cell_op_t ops  [lebuf_pkg::LINE_CELLS];

	for (genvar i = 0; i < lebuf_pkg::LINE_CELLS; i++) begin : g_cell
		localparam logic [5:0] IDX = 6'(i);

		always_comb begin
			ops[i] = lebuf_pkg::CELL_HOLD;
			case (ctrl.mode)
				lebuf_pkg::CH_ROTATE: ops[i] = lebuf_pkg::CELL_FROM_RIGHT;
				lebuf_pkg::CH_INSERT: begin
					if (IDX > ctrl.pos) begin
						ops[i] = lebuf_pkg::CELL_FROM_LEFT;
					end else if (IDX == ctrl.pos) begin
						ops[i] = lebuf_pkg::CELL_LOAD;
					end
				end
				lebuf_pkg::CH_REMOVE: begin
					if (IDX >= ctrl.pos) begin
						ops[i] = lebuf_pkg::CELL_FROM_RIGHT;
					end
				end
				default: ops[i] = lebuf_pkg::CELL_HOLD;
			endcase
		end

		lebuf_cell u_cell (
			.clk   (clk),
			.op    (ops[i]),
			.key   (ctrl.key),
			.left  (vals[(i + lebuf_pkg::LINE_CELLS - 1) % lebuf_pkg::LINE_CELLS]),
			.right (vals[(i + 1) % lebuf_pkg::LINE_CELLS]),
			.value (vals[i])
		);
	end

	assign head = vals[0];

endmodule

// ----- hw/rtl/line_edit_buffer.sv -----
// ----------------------------------------------------------------------------
// Line edit buffer
// Keeps one line of characters with a cursor and emits cursor move, redraw and line beats.
// ----------------------------------------------------------------------------
// Cursor keys: one result beat in the cycle after acceptance (none for left or right at a line end); busy stays low.
// Edits and enter: the cell ring makes one full rotation, busy is high while it
// turns, and beats leave through the state register and then the output register.
// Throughput is one cursor key every cycle while busy is low; an edit waits for the rotation to end.
// Reset empties the line, homes the cursor and loads the register defaults.
module line_edit_buffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] kind,
	input  logic [7:0] key_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       strobe,
	output logic [1:0] out_kind,
	output logic [5:0] position,
	output logic [7:0] char_value,
	output logic [6:0] cursor_column,
	output logic [5:0] line_length,
	output logic       last
);

	lebuf_pkg::state_t      state_q, state_d;
	lebuf_pkg::scan_mode_t  mode_q, mode_d;
	lebuf_pkg::chain_ctrl_t ctrl;
	lebuf_pkg::out_kind_t   out_kind_q, scan_kind;

	logic [5:0] step_q, step_d;
	logic [5:0] len_q, len_d;
	logic [5:0] cur_q, cur_d;
	logic [6:0] max_len_q;
	logic [5:0] origin_col_q;
	logic       move_emit, ins_ok;
	logic [7:0] head;
	logic [6:0] col_sum;
	logic       scan_emit, scan_last;
	logic [5:0] scan_pos;
	logic [7:0] scan_char;

	logic       strobe_q, last_q;
	logic [5:0] position_q, line_length_q;
	logic [7:0] char_q;
	logic [6:0] cursor_col_q;

	lebuf_chain u_chain (
		.clk  (clk),
		.ctrl (ctrl),
		.head (head)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q == lebuf_pkg::ST_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= lebuf_pkg::MAX_LEN_RESET;
			origin_col_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lebuf_pkg::CFG_MAX_LEN:    max_len_q    <= cfg_data;
				lebuf_pkg::CFG_ORIGIN_COL: origin_col_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lebuf_pkg::ST_IDLE;
			mode_q  <= lebuf_pkg::SCAN_REDRAW;
			step_q  <= '0;
			len_q   <= '0;
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			step_q  <= step_d;
			len_q   <= len_d;
			cur_q   <= cur_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		step_d    = step_q;
		len_d     = len_q;
		cur_d     = cur_q;
		move_emit = 1'b0;
		ctrl.mode = lebuf_pkg::CH_HOLD;
		ctrl.pos  = cur_q;
		ctrl.key  = key_byte;
		ins_ok    = (7'(len_q) + 7'd1 < max_len_q)
			&& (7'(len_q) + 7'd1 < 7'(lebuf_pkg::CAPACITY))
			&& (7'(origin_col_q) + 7'(len_q) < 7'(lebuf_pkg::SCREEN_COLS));
		unique case (state_q)
			lebuf_pkg::ST_IDLE: begin
				if (start) begin
					unique case (kind)
						lebuf_pkg::KIND_BYTE: begin
							if (key_byte == lebuf_pkg::KEY_ENTER) begin
								state_d = lebuf_pkg::ST_SCAN;
								mode_d  = lebuf_pkg::SCAN_ENTER;
								step_d  = '0;
							end else if (key_byte == lebuf_pkg::KEY_BACKSPACE) begin
								if (cur_q != '0) begin
									ctrl.mode = lebuf_pkg::CH_REMOVE;
									ctrl.pos  = cur_q - 6'd1;
									len_d     = len_q - 6'd1;
									cur_d     = cur_q - 6'd1;
									state_d   = lebuf_pkg::ST_SCAN;
									mode_d    = lebuf_pkg::SCAN_REDRAW;
									step_d    = '0;
								end
							end else if (key_byte >= lebuf_pkg::PRINT_LOW
								&& key_byte <= lebuf_pkg::PRINT_HIGH && ins_ok) begin
								ctrl.mode = lebuf_pkg::CH_INSERT;
								len_d     = len_q + 6'd1;
								cur_d     = cur_q + 6'd1;
								state_d   = lebuf_pkg::ST_SCAN;
								mode_d    = lebuf_pkg::SCAN_REDRAW;
								step_d    = '0;
							end
						end
						lebuf_pkg::KIND_DELETE: begin
							if (cur_q < len_q) begin
								ctrl.mode = lebuf_pkg::CH_REMOVE;
								len_d     = len_q - 6'd1;
								state_d   = lebuf_pkg::ST_SCAN;
								mode_d    = lebuf_pkg::SCAN_REDRAW;
								step_d    = '0;
							end
						end
						lebuf_pkg::KIND_LEFT: begin
							if (cur_q != '0) begin
								cur_d     = cur_q - 6'd1;
								move_emit = 1'b1;
							end
						end
						lebuf_pkg::KIND_RIGHT: begin
							if (cur_q < len_q) begin
								cur_d     = cur_q + 6'd1;
								move_emit = 1'b1;
							end
						end
						lebuf_pkg::KIND_HOME: begin
							cur_d     = '0;
							move_emit = 1'b1;
						end
						lebuf_pkg::KIND_END: begin
							cur_d     = len_q;
							move_emit = 1'b1;
						end
						default: ;
					endcase
				end
			end
			lebuf_pkg::ST_SCAN: begin
				ctrl.mode = lebuf_pkg::CH_ROTATE;
				step_d    = step_q + 6'd1;
				if (step_q == lebuf_pkg::STEP_LAST) begin
					state_d = lebuf_pkg::ST_IDLE;
					if (mode_q == lebuf_pkg::SCAN_ENTER) begin
						len_d = '0;
						cur_d = '0;
					end
				end
			end
			default: state_d = lebuf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		col_sum   = 7'(origin_col_q) + 7'(step_q);
		scan_emit = 1'b0;
		scan_last = 1'b0;
		scan_kind = lebuf_pkg::OUT_CELL;
		scan_pos  = col_sum[5:0];
		scan_char = (step_q < len_q) ? head : lebuf_pkg::SPACE_CHAR;
		if (state_q == lebuf_pkg::ST_SCAN) begin
			if (mode_q == lebuf_pkg::SCAN_REDRAW) begin
				scan_emit = (col_sum < 7'(lebuf_pkg::SCREEN_COLS));
				scan_last = (col_sum == 7'(lebuf_pkg::SCREEN_COLS - 1));
			end else if (step_q < len_q) begin
				scan_emit = 1'b1;
				scan_kind = lebuf_pkg::OUT_CHAR;
				scan_pos  = step_q;
				scan_char = head;
			end else if (step_q == len_q) begin
				scan_emit = 1'b1;
				scan_last = 1'b1;
				scan_kind = lebuf_pkg::OUT_DONE;
				scan_pos  = '0;
				scan_char = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= move_emit || scan_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (move_emit) begin
			out_kind_q    <= lebuf_pkg::OUT_MOVE;
			position_q    <= '0;
			char_q        <= '0;
			cursor_col_q  <= 7'(origin_col_q) + 7'(cur_d);
			line_length_q <= len_q;
			last_q        <= 1'b1;
		end else if (scan_emit) begin
			out_kind_q    <= scan_kind;
			position_q    <= scan_pos;
			char_q        <= scan_char;
			cursor_col_q  <= 7'(origin_col_q) + 7'(cur_q);
			line_length_q <= len_q;
			last_q        <= scan_last;
		end
	end

	assign strobe        = strobe_q;
	assign out_kind      = out_kind_q;
	assign position      = position_q;
	assign char_value    = char_q;
	assign cursor_column = cursor_col_q;
	assign line_length   = line_length_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("Cursor index is past the end of the line.");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lebuf_pkg::ST_SCAN && step_q == lebuf_pkg::STEP_LAST)
		|=> (state_q == lebuf_pkg::ST_IDLE))
		else $error("Ring rotation did not end after a full turn.");

	a_enter_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lebuf_pkg::ST_SCAN && mode_q == lebuf_pkg::SCAN_ENTER
		&& step_q == lebuf_pkg::STEP_LAST) |=> (len_q == '0 && cur_q == '0))
		else $error("Line was not cleared after enter.");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && out_kind == lebuf_pkg::OUT_DONE) |-> last)
		else $error("Line finished beat is not marked as last.");

	a_no_move_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lebuf_pkg::ST_SCAN) |-> !move_emit)
		else $error("Cursor move beat raised during a ring rotation.");
`endif

endmodule
